// File: rtl/escaped_frame_receiver_crc16_assert.svh
// Assertion macros shared by the escaped frame receiver modules.
`ifndef ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_CRC16_ASSERT_SVH
`ifndef SYNTHESIS
`define EFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EFR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EFR_ASSERT(name, prop, msg)
`define EFR_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

// File: rtl/efr_pkg.sv
// Types, constants and the CRC-16 step shared by the escaped frame receiver.
`default_nettype none
package efr_pkg;

  localparam logic [7:0] MARK_START = 8'hFE;
  localparam logic [7:0] MARK_ESC = 8'hFD;
  localparam logic [7:0] ESC_CODE_START = 8'h01;
  localparam logic [7:0] ESC_CODE_ESC = 8'h02;
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] MIN_FRAME_LENGTH = 16'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [1:0] VERDICT_OK = 2'd0;
  localparam logic [1:0] VERDICT_CRC = 2'd1;
  localparam logic [1:0] VERDICT_SHORT = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_CMD = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_CRC_HI = 3'd6
  } phase_t;

  typedef struct packed {
    logic start;
    logic [7:0] data;
  } token_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/escaped_frame_receiver_crc16.sv
// Top level of the escaped serial frame receiver with CRC-16 check.
//
//   Port group  Direction  Handshake              Contents
//   in_*        input      in_valid / in_ready    one raw received byte
//   out_*       output     out_valid / out_ready  payload byte or end-of-frame verdict
//   cfg_*       input      cfg_valid / cfg_ready  expected command byte
//
// One byte is accepted per cycle unless the queue is full; the parser registers each result.
// The front end writes the queue in the accepting cycle; the parser takes one token per
// cycle unless a result waits for out_ready; meanwhile the queue of QUEUE_DEPTH tokens keeps
// taking bytes until it is full. Reset clears the escape state, the token queue and the
// parser; no clearing pass. cfg_ready is always high.
`default_nettype none
module escaped_frame_receiver_crc16 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_item_kind,
  output logic [7:0]      out_payload_byte,
  output logic [1:0]      out_verdict,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_expected_command
);

  logic queue_full;
  logic push_valid;
  efr_pkg::token_t push_token;
  logic pop_valid;
  logic pop_ready;
  efr_pkg::token_t pop_token;

  assign cfg_ready = 1'b1;

  efr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_token (push_token)
  );

  efr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_token (push_token),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_token  (pop_token)
  );

  efr_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid && cfg_ready),
    .cfg_expected_command (cfg_expected_command),
    .pop_valid            (pop_valid),
    .pop_ready            (pop_ready),
    .pop_token            (pop_token),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_item_kind        (out_item_kind),
    .out_payload_byte     (out_payload_byte),
    .out_verdict          (out_verdict)
  );

endmodule
`default_nettype wire

// File: rtl/efr_front.sv
// Front end: takes raw bytes, removes escaping and emits start and data tokens.
`default_nettype none
`include "escaped_frame_receiver_crc16_assert.svh"
module efr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_rx_byte,
  input  wire logic            queue_full,
  output logic                 push_valid,
  output efr_pkg::token_t      push_token
);

  logic esc_r;
  logic esc_nxt;
  logic accept;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;

  always_comb begin
    esc_nxt = esc_r;
    push_valid = 1'b0;
    push_token.start = 1'b0;
    push_token.data = in_rx_byte;
    if (accept) begin
      if (in_rx_byte == efr_pkg::MARK_START) begin
        esc_nxt = 1'b0;
        push_valid = 1'b1;
        push_token.start = 1'b1;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        if (in_rx_byte == efr_pkg::ESC_CODE_START) begin
          push_valid = 1'b1;
          push_token.data = efr_pkg::MARK_START;
        end else if (in_rx_byte == efr_pkg::ESC_CODE_ESC) begin
          push_valid = 1'b1;
          push_token.data = efr_pkg::MARK_ESC;
        end
      end else if (in_rx_byte == efr_pkg::MARK_ESC) begin
        esc_nxt = 1'b1;
      end else begin
        push_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r <= 1'b0;
    end else begin
      esc_r <= esc_nxt;
    end
  end

  `EFR_ASSERT(a_marker_clears_escape, accept && in_rx_byte == efr_pkg::MARK_START |=> !esc_r, "escape state survived a start marker")
  `EFR_ASSERT(a_no_push_when_full, queue_full |-> !push_valid, "token pushed into a full queue")

endmodule
`default_nettype wire

// File: rtl/efr_queue.sv
// Short token queue between the front end and the frame parser.
`default_nettype none
`include "escaped_frame_receiver_crc16_assert.svh"
module efr_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  input  wire efr_pkg::token_t push_token,
  output logic                 full,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output efr_pkg::token_t      pop_token
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  efr_pkg::token_t entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic pop_fire;

  assign full = (count_r == FULL_COUNT);
  assign pop_valid = (count_r != '0);
  assign pop_fire = pop_valid && pop_ready;
  assign pop_token = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push_valid) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_valid && !pop_fire) begin
      count_nxt = count_r + 1'b1;
    end else if (!push_valid && pop_fire) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      entries_r[wr_ptr_r] <= push_token;
    end
  end

  `EFR_ASSERT(a_count_bound, count_r <= FULL_COUNT, "queue count exceeds its depth")
  `EFR_ASSERT(a_count_grows, push_valid && !pop_fire |=> count_r == $past(count_r) + 1'b1, "queue count did not follow a push")

endmodule
`default_nettype wire

// File: rtl/efr_back.sv
// Frame parser: length, command, payload and CRC check, with the result register.
`default_nettype none
`include "escaped_frame_receiver_crc16_assert.svh"
module efr_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_valid,
  input  wire logic [7:0]      cfg_expected_command,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire efr_pkg::token_t pop_token,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_item_kind,
  output logic [7:0]           out_payload_byte,
  output logic [1:0]           out_verdict
);

  efr_pkg::phase_t phase_r;
  efr_pkg::phase_t phase_nxt;
  logic [7:0] expected_r;
  logic [7:0] len_lo_r;
  logic [7:0] len_lo_nxt;
  logic [15:0] bytes_left_r;
  logic [15:0] bytes_left_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [7:0] crc_lo_r;
  logic [7:0] crc_lo_nxt;
  logic match_r;
  logic match_nxt;
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_item_kind_r;
  logic out_item_kind_nxt;
  logic [7:0] out_payload_byte_r;
  logic [7:0] out_payload_byte_nxt;
  logic [1:0] out_verdict_r;
  logic [1:0] out_verdict_nxt;
  logic pop_fire;
  logic [15:0] crc_step;
  logic [15:0] frame_length;
  logic [15:0] bytes_left_dec;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop_fire = pop_valid && pop_ready;
  assign crc_step = efr_pkg::crc16_update(crc_r, pop_token.data);
  assign frame_length = {pop_token.data, len_lo_r};
  assign bytes_left_dec = bytes_left_r - 16'd1;

  assign out_valid = out_valid_r;
  assign out_item_kind = out_item_kind_r;
  assign out_payload_byte = out_payload_byte_r;
  assign out_verdict = out_verdict_r;

  always_comb begin
    phase_nxt = phase_r;
    len_lo_nxt = len_lo_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt = crc_r;
    crc_lo_nxt = crc_lo_r;
    match_nxt = match_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_kind_nxt = out_item_kind_r;
    out_payload_byte_nxt = out_payload_byte_r;
    out_verdict_nxt = out_verdict_r;
    if (pop_fire) begin
      if (pop_token.start) begin
        phase_nxt = efr_pkg::PH_LEN_LO;
        bytes_left_nxt = '0;
        crc_nxt = '0;
        crc_lo_nxt = '0;
        match_nxt = 1'b0;
      end else begin
        case (phase_r)
          efr_pkg::PH_LEN_LO: begin
            len_lo_nxt = pop_token.data;
            crc_nxt = crc_step;
            phase_nxt = efr_pkg::PH_LEN_HI;
          end
          efr_pkg::PH_LEN_HI: begin
            crc_nxt = crc_step;
            if (frame_length < efr_pkg::MIN_FRAME_LENGTH) begin
              phase_nxt = efr_pkg::PH_HUNT;
              out_valid_nxt = 1'b1;
              out_item_kind_nxt = efr_pkg::KIND_VERDICT;
              out_payload_byte_nxt = '0;
              out_verdict_nxt = efr_pkg::VERDICT_SHORT;
            end else begin
              bytes_left_nxt = frame_length - efr_pkg::MIN_FRAME_LENGTH;
              phase_nxt = efr_pkg::PH_CMD;
            end
          end
          efr_pkg::PH_CMD: begin
            match_nxt = (pop_token.data == expected_r);
            crc_nxt = crc_step;
            phase_nxt = (bytes_left_r == '0) ? efr_pkg::PH_CRC_LO : efr_pkg::PH_PAYLOAD;
          end
          efr_pkg::PH_PAYLOAD: begin
            crc_nxt = crc_step;
            bytes_left_nxt = bytes_left_dec;
            if (bytes_left_dec == '0) begin
              phase_nxt = efr_pkg::PH_CRC_LO;
            end
            if (match_r) begin
              out_valid_nxt = 1'b1;
              out_item_kind_nxt = efr_pkg::KIND_PAYLOAD;
              out_payload_byte_nxt = pop_token.data;
              out_verdict_nxt = efr_pkg::VERDICT_OK;
            end
          end
          efr_pkg::PH_CRC_LO: begin
            crc_lo_nxt = pop_token.data;
            phase_nxt = efr_pkg::PH_CRC_HI;
          end
          efr_pkg::PH_CRC_HI: begin
            phase_nxt = efr_pkg::PH_HUNT;
            if (match_r) begin
              out_valid_nxt = 1'b1;
              out_item_kind_nxt = efr_pkg::KIND_VERDICT;
              out_payload_byte_nxt = '0;
              out_verdict_nxt = ({pop_token.data, crc_lo_r} == crc_r) ?
                                efr_pkg::VERDICT_OK : efr_pkg::VERDICT_CRC;
            end
          end
          default: begin
            phase_nxt = efr_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= efr_pkg::PH_HUNT;
      expected_r <= '0;
      bytes_left_r <= '0;
      crc_r <= '0;
      crc_lo_r <= '0;
      match_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (cfg_valid) begin
        expected_r <= cfg_expected_command;
      end
      bytes_left_r <= bytes_left_nxt;
      crc_r <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      match_r <= match_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r <= len_lo_nxt;
    out_item_kind_r <= out_item_kind_nxt;
    out_payload_byte_r <= out_payload_byte_nxt;
    out_verdict_r <= out_verdict_nxt;
  end

  `EFR_ASSERT(a_payload_has_bytes, phase_r == efr_pkg::PH_PAYLOAD |-> bytes_left_r != '0, "payload phase entered with no bytes left")
  `EFR_ASSERT(a_start_restarts, pop_fire && pop_token.start |=> phase_r == efr_pkg::PH_LEN_LO, "start token did not restart the frame")
  `EFR_ASSERT(a_payload_verdict_zero, out_valid_r && out_item_kind_r == efr_pkg::KIND_PAYLOAD |-> out_verdict_r == efr_pkg::VERDICT_OK, "payload item carries a verdict")
  `EFR_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && phase_r == efr_pkg::PH_HUNT, "reset did not clear the parser")

endmodule
`default_nettype wire

// File: verif/escaped_frame_receiver_crc16_test.sv
// Self-checking testbench for the escaped frame receiver: random framed byte streams vs. a predictor.
`timescale 1ns / 1ps
module escaped_frame_receiver_crc16_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 205;
  localparam int LONG_HOLD = 300;
  localparam int DIR_ROWS = 30;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [1:0] verd;
  } frame_item_t;

  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic        has;
    frame_item_t res;
  } dir_row_t;

  localparam frame_item_t NO_ITEM = '0;
  localparam frame_item_t SHORT_ITEM =
    {efr_pkg::KIND_VERDICT, 8'h00, efr_pkg::VERDICT_SHORT};
  localparam frame_item_t GOOD_ITEM =
    {efr_pkg::KIND_VERDICT, 8'h00, efr_pkg::VERDICT_OK};

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    {8'h55, 1'b0, 1'b0, NO_ITEM},
    {8'hFE, 1'b0, 1'b0, NO_ITEM},
    {8'h02, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b1, 1'b1, SHORT_ITEM},
    {8'hFE, 1'b0, 1'b0, NO_ITEM},
    {8'h03, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b0, 1'b0, NO_ITEM},
    {8'h3C, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b1, 1'b1, GOOD_ITEM},
    {8'hFE, 1'b0, 1'b0, NO_ITEM},
    {8'h06, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b0, 1'b0, NO_ITEM},
    {8'hFD, 1'b0, 1'b0, NO_ITEM},
    {8'h01, 1'b0, 1'b0, NO_ITEM},
    {8'hFD, 1'b0, 1'b0, NO_ITEM},
    {8'h07, 1'b0, 1'b0, NO_ITEM},
    {8'hFD, 1'b0, 1'b0, NO_ITEM},
    {8'h02, 1'b0, 1'b0, NO_ITEM},
    {8'hFF, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b0, 1'b0, NO_ITEM},
    {8'hFD, 1'b0, 1'b0, NO_ITEM},
    {8'hFE, 1'b0, 1'b0, NO_ITEM},
    {8'h04, 1'b0, 1'b0, NO_ITEM},
    {8'h00, 1'b0, 1'b0, NO_ITEM},
    {8'h11, 1'b0, 1'b0, NO_ITEM},
    {8'hAB, 1'b0, 1'b0, NO_ITEM},
    {8'h12, 1'b0, 1'b0, NO_ITEM},
    {8'h34, 1'b0, 1'b0, NO_ITEM}
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_item_kind;
  logic [7:0] out_payload_byte;
  logic [1:0] out_verdict;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_expected_command;

  efr_pkg::phase_t rx_phase;
  logic        esc_seen;
  logic [15:0] len_field;
  logic [15:0] remaining;
  logic [15:0] crc_acc;
  logic [7:0]  crc_lo_field;
  logic        cmd_hit;
  logic [7:0]  exp_cmd;

  frame_item_t pending_items[$];
  logic [7:0]  rx_plan[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  logic        tx_typed = 1'b0;
  logic        tx_has = 1'b0;
  frame_item_t tx_res = '0;
  bit          send_busy = 1'b1;
  bit          recv_busy = 1'b1;
  bit          long_hold_req = 1'b0;

  escaped_frame_receiver_crc16 uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item_kind       (out_item_kind),
    .out_payload_byte    (out_payload_byte),
    .out_verdict         (out_verdict),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_expected_command(cfg_expected_command)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = crc[15] ^ d[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ efr_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  task automatic parse_decoded(input logic [7:0] b, output logic has, output frame_item_t res);
    has = 1'b0;
    res = NO_ITEM;
    case (rx_phase)
      efr_pkg::PH_LEN_LO: begin
        len_field = {8'h00, b};
        crc_acc = crc_next(crc_acc, b);
        rx_phase = efr_pkg::PH_LEN_HI;
      end
      efr_pkg::PH_LEN_HI: begin
        len_field[15:8] = b;
        crc_acc = crc_next(crc_acc, b);
        if (len_field < efr_pkg::MIN_FRAME_LENGTH) begin
          rx_phase = efr_pkg::PH_HUNT;
          has = 1'b1;
          res = SHORT_ITEM;
        end else begin
          remaining = len_field - efr_pkg::MIN_FRAME_LENGTH;
          rx_phase = efr_pkg::PH_CMD;
        end
      end
      efr_pkg::PH_CMD: begin
        cmd_hit = (b == exp_cmd);
        crc_acc = crc_next(crc_acc, b);
        rx_phase = (remaining == 16'd0) ? efr_pkg::PH_CRC_LO : efr_pkg::PH_PAYLOAD;
      end
      efr_pkg::PH_PAYLOAD: begin
        crc_acc = crc_next(crc_acc, b);
        if (remaining != 16'd0) begin
          remaining = remaining - 16'd1;
        end
        if (remaining == 16'd0) begin
          rx_phase = efr_pkg::PH_CRC_LO;
        end
        if (cmd_hit) begin
          has = 1'b1;
          res = {efr_pkg::KIND_PAYLOAD, b, efr_pkg::VERDICT_OK};
        end
      end
      efr_pkg::PH_CRC_LO: begin
        crc_lo_field = b;
        rx_phase = efr_pkg::PH_CRC_HI;
      end
      efr_pkg::PH_CRC_HI: begin
        rx_phase = efr_pkg::PH_HUNT;
        if (cmd_hit) begin
          has = 1'b1;
          res = {efr_pkg::KIND_VERDICT, 8'h00,
                 ({b, crc_lo_field} == crc_acc) ? efr_pkg::VERDICT_OK : efr_pkg::VERDICT_CRC};
        end
      end
      default: begin
        rx_phase = efr_pkg::PH_HUNT;
      end
    endcase
  endtask

  task automatic decode_rx(input logic [7:0] raw, output logic has, output frame_item_t res);
    has = 1'b0;
    res = NO_ITEM;
    if (raw == efr_pkg::MARK_START) begin
      rx_phase = efr_pkg::PH_LEN_LO;
      esc_seen = 1'b0;
      len_field = '0;
      remaining = '0;
      crc_acc = '0;
      crc_lo_field = '0;
      cmd_hit = 1'b0;
    end else if (rx_phase == efr_pkg::PH_HUNT) begin
      esc_seen = 1'b0;
    end else if (esc_seen) begin
      esc_seen = 1'b0;
      if (raw == efr_pkg::ESC_CODE_START) begin
        parse_decoded(efr_pkg::MARK_START, has, res);
      end else if (raw == efr_pkg::ESC_CODE_ESC) begin
        parse_decoded(efr_pkg::MARK_ESC, has, res);
      end
    end else if (raw == efr_pkg::MARK_ESC) begin
      esc_seen = 1'b1;
    end else begin
      parse_decoded(raw, has, res);
    end
  endtask

  task automatic queue_item(input frame_item_t res);
    pending_items = {pending_items, res};
  endtask

  always @(posedge clk) begin : monitor
    logic        has;
    frame_item_t res;
    frame_item_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_rx(in_rx_byte, has, res);
        if (tx_typed) begin
          has = tx_has;
          res = tx_res;
        end
        if (has) begin
          queue_item(res);
        end
      end
      if (out_valid && out_ready) begin
        if (pending_items.size() == 0) begin
          $error("unexpected result: item_kind %0d payload_byte 0x%02h verdict %0d",
                 out_item_kind, out_payload_byte, out_verdict);
          fail_count++;
        end else begin
          want = pending_items.pop_front();
          if (out_item_kind !== want.kind) begin
            $error("item_kind: expected %0d, actual %0d", want.kind, out_item_kind);
            fail_count++;
          end
          if (out_payload_byte !== want.data) begin
            $error("payload_byte: expected 0x%02h, actual 0x%02h", want.data, out_payload_byte);
            fail_count++;
          end
          if (out_verdict !== want.verd) begin
            $error("verdict: expected %0d, actual %0d", want.verd, out_verdict);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = recv_busy ? $urandom_range(0, 9) : 0;
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid && out_ready));
    end
  end

  task automatic send_rx(input logic [7:0] b, input logic typed, input logic has,
                         input frame_item_t res);
    int gap;
    gap = send_busy ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    tx_typed = typed;
    tx_has = has;
    tx_res = res;
    in_rx_byte = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_expected_command(input logic [7:0] v);
    cfg_expected_command = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    exp_cmd = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0: return efr_pkg::MARK_START;
      1: return efr_pkg::MARK_ESC;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic plan_raw(input logic [7:0] b);
    rx_plan = {rx_plan, b};
  endtask

  task automatic plan_escaped(input logic [7:0] b);
    logic [7:0] bad;
    if ($urandom_range(0, 49) == 0) begin
      bad = 8'($urandom_range(0, 255));
      if (bad == efr_pkg::ESC_CODE_START || bad == efr_pkg::ESC_CODE_ESC ||
          bad == efr_pkg::MARK_START) begin
        bad = 8'h00;
      end
      plan_raw(efr_pkg::MARK_ESC);
      plan_raw(bad);
    end
    if (b == efr_pkg::MARK_START) begin
      plan_raw(efr_pkg::MARK_ESC);
      plan_raw(efr_pkg::ESC_CODE_START);
    end else if (b == efr_pkg::MARK_ESC) begin
      plan_raw(efr_pkg::MARK_ESC);
      plan_raw(efr_pkg::ESC_CODE_ESC);
    end else begin
      plan_raw(b);
    end
  endtask

  task automatic plan_frame();
    int          sel;
    int          plen;
    logic [15:0] len;
    logic [15:0] crc;
    logic [7:0]  cmd;
    logic [7:0]  d;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(0, 8);
      len = 16'(plen + 3);
      cmd = ($urandom_range(0, 4) != 0) ? exp_cmd : pick_data();
      plan_raw(efr_pkg::MARK_START);
      crc = crc_next(16'h0000, len[7:0]);
      plan_escaped(len[7:0]);
      crc = crc_next(crc, len[15:8]);
      plan_escaped(len[15:8]);
      crc = crc_next(crc, cmd);
      plan_escaped(cmd);
      for (int i = 0; i < plen; i++) begin
        d = pick_data();
        crc = crc_next(crc, d);
        plan_escaped(d);
      end
      if ($urandom_range(0, 6) == 0) begin
        crc = crc ^ 16'($urandom_range(1, 65535));
      end
      plan_escaped(crc[7:0]);
      plan_escaped(crc[15:8]);
    end else if (sel < 80) begin
      plan_raw(efr_pkg::MARK_START);
      plan_escaped(8'($urandom_range(0, 2)));
      plan_escaped(8'h00);
    end else if (sel < 90) begin
      // Abandoned frame with any length; the next start marker cuts it off.
      plan_raw(efr_pkg::MARK_START);
      plan_escaped(pick_data());
      plan_escaped(pick_data());
      plan_escaped(exp_cmd);
      repeat ($urandom_range(0, 10)) plan_escaped(pick_data());
      if ($urandom_range(0, 1) == 1) begin
        plan_raw(efr_pkg::MARK_ESC);
      end
    end else begin
      repeat ($urandom_range(1, 5)) plan_raw(pick_data());
    end
  endtask

  function automatic logic [7:0] command_for_phase(input int p);
    case (p)
      0: return 8'hFF;
      1: return 8'h00;
      3: return efr_pkg::MARK_START;
      4: return efr_pkg::MARK_ESC;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin : stimulus
    int p;
    int tail;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_expected_command = 8'h00;
    rx_phase = efr_pkg::PH_HUNT;
    esc_seen = 1'b0;
    len_field = '0;
    remaining = '0;
    crc_acc = '0;
    crc_lo_field = '0;
    cmd_hit = 1'b0;
    exp_cmd = 8'h00;
    tail = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_rx(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].has, DIRECTED[i].res);
    end
    in_valid = 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_expected_command(command_for_phase(p));
      send_busy = (p != 1 && p != 2);
      recv_busy = (p != 1);
      long_hold_req = (p == 2);
      // A frame left open by the last phase ends in this one, with its command sent here if tail is 1.
      if (tail == 1) begin
        plan_escaped(exp_cmd);
      end
      if (tail != 0) begin
        repeat (3) plan_escaped(pick_data());
      end
      while (rx_plan.size() < PHASE_ITEMS) plan_frame();
      tail = p % 3;
      if (tail != 0) begin
        plan_raw(efr_pkg::MARK_START);
        plan_raw(8'h04);
        plan_raw(8'h00);
      end
      if (tail == 2) begin
        plan_escaped(exp_cmd);
      end
      while (rx_plan.size() != 0) begin
        send_rx(rx_plan.pop_front(), 1'b0, 1'b0, NO_ITEM);
      end
      in_valid = 1'b0;
    end

    wait_drained();
    if (fail_count == 0 && pending_items.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
